FILE: rtl/core/nucc_pkg.sv
// Shared types, codes and helper functions for the nucleotide composition counter.
package nucc_pkg;

    // Field widths of the channel words.
    localparam int FIELD_W    = 48;
    localparam int STAT_IDX_W = 5;
    localparam int CODE_W     = 3;

    // Default width of the internal counters.
    localparam int COUNT_WIDTH_DEF = 48;

    // Statistic layout of one report.
    localparam int NUM_STATS   = 23;
    localparam int BASIC_STATS = 7;
    localparam int IDX_LEN     = 0;
    localparam int IDX_BASE    = 1;
    localparam int IDX_CPG     = 6;
    localparam int IDX_PAIR    = 7;

    // Input function codes.
    localparam logic [1:0] FUNC_BASE    = 2'd0;
    localparam logic [1:0] FUNC_END_SEQ = 2'd1;
    localparam logic [1:0] FUNC_END_RUN = 2'd2;

    // Base codes.
    localparam logic [CODE_W-1:0] CODE_A  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_N  = 3'd4;
    localparam logic [CODE_W-1:0] NO_BASE = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAIR_STATS  = 2'd0;
    localparam logic [1:0] CFG_BOTH_STRAND = 2'd1;
    localparam logic [1:0] CFG_TOTALS_ONLY = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] base_char;
    } in_word_t;

    typedef struct packed {
        logic                  scope;
        logic [STAT_IDX_W-1:0] stat_index;
        logic [FIELD_W-1:0]    count_value;
        logic                  last;
    } out_word_t;

    // Map an ASCII character to a base code; U is read as T.
    function automatic logic [CODE_W-1:0] classify(input logic [7:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            "A", "a":           code = CODE_A;
            "C", "c":           code = CODE_C;
            "G", "g":           code = CODE_G;
            "T", "t", "U", "u": code = CODE_T;
            default:            code = CODE_N;
        endcase
        return code;
    endfunction

    // Watson-Crick complement; N stays N.
    function automatic logic [CODE_W-1:0] complement(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] comp;
        if (code < CODE_N) begin
            comp = CODE_T - code;
        end else begin
            comp = CODE_N;
        end
        return comp;
    endfunction

endpackage

FILE: rtl/core/nucleotide_composition_counter.sv
// Top level of the nucleotide and dinucleotide composition counter.
//
//  Channel | Ports                    | Word
//  --------+--------------------------+-----------------------------------------
//  input   | s_valid s_ready s_data   | func, base_char
//  result  | m_valid m_ready m_data   | scope, stat_index, count_value, last
//  config  | cfg_we cfg_index cfg_wdata | pair_stats_on, both_strands, totals_only
//
// Base characters are taken one per cycle unless stalled; each passes an input
// register and updates the sequence counters in the next cycle. A report streams
// 7 words, or 23 with pair statistics, one per cycle unless stalled, from a snapshot
// buffer through the output register. An end of sequence or end of run waits in
// the input register while the previous report is still draining. Reset clears
// all counters and handshake state at once; no clearing pass is needed.
module nucleotide_composition_counter #(
    parameter int COUNT_WIDTH = nucc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nucc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output nucc_pkg::out_word_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic                cfg_wdata
);
    import nucc_pkg::*;

    localparam logic [STAT_IDX_W-1:0] LAST_BASIC = STAT_IDX_W'(BASIC_STATS - 1);
    localparam logic [STAT_IDX_W-1:0] LAST_FULL  = STAT_IDX_W'(NUM_STATS - 1);

    // Configuration registers.
    logic pair_stats_reg, both_strands_reg, totals_only_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_stats_reg   <= 1'b0;
            both_strands_reg <= 1'b0;
            totals_only_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PAIR_STATS:  pair_stats_reg   <= cfg_wdata;
                CFG_BOTH_STRAND: both_strands_reg <= cfg_wdata;
                CFG_TOTALS_ONLY: totals_only_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: function code and classified base.
    logic              in_valid_reg;
    logic [1:0]        in_func_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic              in_stall, in_fire;
    logic              rpt_active_reg;

    assign in_stall = in_valid_reg && rpt_active_reg &&
                      (in_func_reg == FUNC_END_SEQ || in_func_reg == FUNC_END_RUN);
    assign in_fire  = in_valid_reg && !in_stall;
    assign s_ready  = !in_stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_func_reg <= s_data.func;
            in_code_reg <= classify(s_data.base_char);
        end
    end

    // Counter state.
    logic [COUNT_WIDTH-1:0] seq_reg    [NUM_STATS];
    logic [COUNT_WIDTH-1:0] seq_next   [NUM_STATS];
    logic [COUNT_WIDTH-1:0] total_reg  [NUM_STATS];
    logic [COUNT_WIDTH-1:0] total_next [NUM_STATS];
    logic [CODE_W-1:0]      prior_reg, prior_next;
    logic [CODE_W-1:0]      prior_comp_reg, prior_comp_next;

    // Per-statistic increment of one base character, 0 to 2.
    logic [1:0]        inc [NUM_STATS];
    logic [CODE_W-1:0] comp_code;
    logic              fwd_pair_ok, rev_pair_ok, is_cpg;
    logic [3:0]        fwd_pair, rev_pair;

    assign comp_code   = complement(in_code_reg);
    assign fwd_pair_ok = (prior_reg < CODE_N) && (in_code_reg < CODE_N);
    assign rev_pair_ok = (comp_code < CODE_N) && (prior_comp_reg < CODE_N);
    assign fwd_pair    = {prior_reg[1:0], in_code_reg[1:0]};
    assign rev_pair    = {comp_code[1:0], prior_comp_reg[1:0]};
    assign is_cpg      = (prior_reg == CODE_C) && (in_code_reg == CODE_G);

    always_comb begin
        for (int k = 0; k < NUM_STATS; k++) begin
            inc[k] = 2'd0;
        end
        inc[IDX_LEN] = both_strands_reg ? 2'd2 : 2'd1;
        for (int b = 0; b < 5; b++) begin
            inc[IDX_BASE + b] = 2'(in_code_reg == CODE_W'(b)) +
                2'(both_strands_reg && (comp_code == CODE_W'(b)));
        end
        // The reverse-strand CpG test reduces to the forward one.
        inc[IDX_CPG] = is_cpg ? (both_strands_reg ? 2'd2 : 2'd1) : 2'd0;
        for (int p = 0; p < 16; p++) begin
            inc[IDX_PAIR + p] = 2'(fwd_pair_ok && (fwd_pair == 4'(p))) +
                2'(both_strands_reg && rev_pair_ok && (rev_pair == 4'(p)));
        end
    end

    // Saturating adds for base updates and for folding into the totals.
    logic [COUNT_WIDTH:0] seq_sum   [NUM_STATS];
    logic [COUNT_WIDTH:0] total_sum [NUM_STATS];

    always_comb begin
        for (int k = 0; k < NUM_STATS; k++) begin
            seq_sum[k]   = {1'b0, seq_reg[k]} + (COUNT_WIDTH + 1)'(inc[k]);
            total_sum[k] = {1'b0, total_reg[k]} + {1'b0, seq_reg[k]};
        end
    end

    // Next counter state per function code.
    always_comb begin
        for (int k = 0; k < NUM_STATS; k++) begin
            seq_next[k]   = seq_reg[k];
            total_next[k] = total_reg[k];
        end
        prior_next      = prior_reg;
        prior_comp_next = prior_comp_reg;
        if (in_fire) begin
            unique case (in_func_reg)
                FUNC_BASE: begin
                    for (int k = 0; k < NUM_STATS; k++) begin
                        seq_next[k] = seq_sum[k][COUNT_WIDTH] ? '1 :
                                      seq_sum[k][COUNT_WIDTH-1:0];
                    end
                    prior_next      = in_code_reg;
                    prior_comp_next = comp_code;
                end
                FUNC_END_SEQ: begin
                    for (int k = 0; k < NUM_STATS; k++) begin
                        total_next[k] = total_sum[k][COUNT_WIDTH] ? '1 :
                                        total_sum[k][COUNT_WIDTH-1:0];
                        seq_next[k]   = '0;
                    end
                    prior_next      = NO_BASE;
                    prior_comp_next = NO_BASE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_STATS; k++) begin
                seq_reg[k]   <= '0;
                total_reg[k] <= '0;
            end
            prior_reg      <= NO_BASE;
            prior_comp_reg <= NO_BASE;
        end else begin
            for (int k = 0; k < NUM_STATS; k++) begin
                seq_reg[k]   <= seq_next[k];
                total_reg[k] <= total_next[k];
            end
            prior_reg      <= prior_next;
            prior_comp_reg <= prior_comp_next;
        end
    end

    // Report snapshot and sequencer.
    logic [COUNT_WIDTH-1:0] rpt_buf_reg [NUM_STATS];
    logic                   rpt_scope_reg;
    logic [STAT_IDX_W-1:0]  rpt_idx_reg, rpt_idx_next;
    logic                   rpt_active_next;
    logic                   rpt_start, rpt_is_total, rpt_last, out_load;

    assign rpt_is_total = (in_func_reg == FUNC_END_RUN);
    assign rpt_start    = in_fire && (rpt_is_total ||
                          (in_func_reg == FUNC_END_SEQ && !totals_only_reg));
    assign rpt_last     = (rpt_idx_reg == (pair_stats_reg ? LAST_FULL : LAST_BASIC));
    assign out_load     = rpt_active_reg && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (rpt_start) begin
            for (int k = 0; k < NUM_STATS; k++) begin
                rpt_buf_reg[k] <= rpt_is_total ? total_reg[k] : seq_reg[k];
            end
            rpt_scope_reg <= rpt_is_total;
        end
    end

    always_comb begin
        rpt_active_next = rpt_active_reg;
        rpt_idx_next    = rpt_idx_reg;
        if (rpt_start) begin
            rpt_active_next = 1'b1;
            rpt_idx_next    = '0;
        end else if (out_load) begin
            rpt_active_next = !rpt_last;
            rpt_idx_next    = rpt_idx_reg + STAT_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpt_active_reg <= 1'b0;
            rpt_idx_reg    <= '0;
        end else begin
            rpt_active_reg <= rpt_active_next;
            rpt_idx_reg    <= rpt_idx_next;
        end
    end

    // Clamp a wide count to the result field, or zero-extend a narrower one.
    logic [COUNT_WIDTH-1:0] rd_word;
    logic [FIELD_W-1:0]     rd_clamped;

    assign rd_word = rpt_buf_reg[rpt_idx_reg];

    generate
        if (COUNT_WIDTH > FIELD_W) begin : g_clamp
            assign rd_clamped = (|rd_word[COUNT_WIDTH-1:FIELD_W]) ? '1 :
                                rd_word[FIELD_W-1:0];
        end else begin : g_extend
            assign rd_clamped = FIELD_W'(rd_word);
        end
    endgenerate

    // Output register.
    logic      m_valid_reg;
    out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.scope       <= rpt_scope_reg;
            m_data_reg.stat_index  <= rpt_idx_reg;
            m_data_reg.count_value <= rd_clamped;
            m_data_reg.last        <= rpt_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/nucc_checker.sv
// Port-level assertions for the composition counter, bound to the top level.
module nucc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input nucc_pkg::out_word_t m_data
);
    import nucc_pkg::*;

    localparam logic [STAT_IDX_W-1:0] LAST_BASIC = STAT_IDX_W'(BASIC_STATS - 1);
    localparam logic [STAT_IDX_W-1:0] LAST_FULL  = STAT_IDX_W'(NUM_STATS - 1);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Within a report the next word follows at once with the next index and scope.
    a_report_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            m_valid && m_data.stat_index == $past(m_data.stat_index) + STAT_IDX_W'(1) &&
            m_data.scope == $past(m_data.scope))
        else $error("report words not consecutive");

    // A new report starts at the length statistic.
    a_report_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> !m_valid || m_data.stat_index == '0)
        else $error("report did not start at index zero");

    // The last word closes a basic or a full report.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |->
            m_data.stat_index == LAST_BASIC || m_data.stat_index == LAST_FULL)
        else $error("last flag on wrong statistic");

endmodule

bind nucleotide_composition_counter nucc_checker u_nucc_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench for the nucleotide composition counter.
`timescale 1ns / 1ps

module tb;
    import nucc_pkg::*;

    localparam int COUNT_W = COUNT_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 250;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [63:0] FIELD_CAP = (64'd1 << FIELD_W) - 64'd1;
    localparam logic [COUNT_W-1:0] CNT_MAX = '1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic cfg_wdata = 1'b0;

    // Predicted block state and configuration.
    logic pairs_cfg, strands_cfg, totals_cfg;
    logic [CODE_W-1:0] prev_code, prev_comp;
    logic [COUNT_W-1:0] seq_cnt [NUM_STATS];
    logic [COUNT_W-1:0] run_cnt [NUM_STATS];
    out_word_t pending_stats[$];

    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned run_left = 0;

    nucleotide_composition_counter #(
        .COUNT_WIDTH(COUNT_W)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: ready stretches, now and then long, broken by short random stalls.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (run_left != 0) begin
            m_ready <= 1'b1;
            run_left <= run_left - 1;
        end else begin
            m_ready <= 1'b1;
            run_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 4);
            stall_left <= $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
        end
    end

    // Compare every accepted result word with the oldest predicted one.
    always @(posedge aclk) begin : check_results
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_stats.size() == 0) begin
                $error("result word with nothing expected: stat_index %0d count %0d",
                       m_data.stat_index, m_data.count_value);
                fail_count++;
            end else begin
                want = pending_stats.pop_front();
                if (m_data.scope !== want.scope) begin
                    $error("scope: expected %0d, got %0d", want.scope, m_data.scope);
                    fail_count++;
                end
                if (m_data.stat_index !== want.stat_index) begin
                    $error("stat_index: expected %0d, got %0d",
                           want.stat_index, m_data.stat_index);
                    fail_count++;
                end
                if (m_data.count_value !== want.count_value) begin
                    $error("count_value (stat %0d): expected %0d, got %0d",
                           want.stat_index, want.count_value, m_data.count_value);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

    // Map a character to its base code, folding lower case onto upper case.
    function automatic logic [CODE_W-1:0] base_code(input logic [7:0] ch);
        logic [7:0] up;
        up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
        if (up == "A") return CODE_A;
        if (up == "C") return CODE_C;
        if (up == "G") return CODE_G;
        if (up == "T" || up == "U") return CODE_T;
        return CODE_N;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_sum(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[COUNT_W] ? CNT_MAX : total[COUNT_W-1:0];
    endfunction

    function automatic void bump(input int idx);
        if (seq_cnt[idx] != CNT_MAX) seq_cnt[idx] = seq_cnt[idx] + COUNT_W'(1);
    endfunction

    // A dinucleotide only counts when both ends are real ACGT bases.
    function automatic void add_pair(input logic [CODE_W-1:0] first,
                                     input logic [CODE_W-1:0] second);
        if (first < CODE_N && second < CODE_N) bump(IDX_PAIR + first * 4 + second);
    endfunction

    function automatic void clear_model();
        pairs_cfg = 1'b0;
        strands_cfg = 1'b0;
        totals_cfg = 1'b0;
        prev_code = NO_BASE;
        prev_comp = NO_BASE;
        for (int k = 0; k < NUM_STATS; k++) begin
            seq_cnt[k] = '0;
            run_cnt[k] = '0;
        end
    endfunction

    // Queue one report of sequence counts or run totals.
    function automatic void queue_report(input logic scope);
        int n;
        logic [63:0] v;
        out_word_t w;
        n = pairs_cfg ? NUM_STATS : BASIC_STATS;
        for (int k = 0; k < n; k++) begin
            v = 64'(scope ? run_cnt[k] : seq_cnt[k]);
            w.scope = scope;
            w.stat_index = STAT_IDX_W'(k);
            w.count_value = (v > FIELD_CAP) ? FIELD_CAP[FIELD_W-1:0] : v[FIELD_W-1:0];
            w.last = (k == n - 1);
            pending_stats.push_back(w);
        end
    endfunction

    // Update the predicted counters for one accepted word.
    function automatic void tally_word(input in_word_t w);
        logic [CODE_W-1:0] code, comp;
        case (w.func)
            FUNC_BASE: begin
                code = base_code(w.base_char);
                comp = (code < CODE_N) ? CODE_T - code : CODE_N;
                bump(IDX_LEN);
                bump(IDX_BASE + code);
                if (prev_code == CODE_C && code == CODE_G) bump(IDX_CPG);
                add_pair(prev_code, code);
                // The reverse strand reads complement pairs backwards.
                if (strands_cfg) begin
                    bump(IDX_LEN);
                    bump(IDX_BASE + comp);
                    if (prev_comp == CODE_G && comp == CODE_C) bump(IDX_CPG);
                    add_pair(comp, prev_comp);
                end
                prev_code = code;
                prev_comp = comp;
            end
            FUNC_END_SEQ: begin
                if (!totals_cfg) queue_report(1'b0);
                for (int k = 0; k < NUM_STATS; k++) begin
                    run_cnt[k] = sat_sum(run_cnt[k], seq_cnt[k]);
                    seq_cnt[k] = '0;
                end
                prev_code = NO_BASE;
                prev_comp = NO_BASE;
            end
            FUNC_END_RUN: begin
                queue_report(1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic in_word_t word_of(input logic [1:0] f, input logic [7:0] ch);
        in_word_t w;
        w.func = f;
        w.base_char = ch;
        return w;
    endfunction

    // Send one word; the sender runs in bursts with random gaps between them.
    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        tally_word(w);
    endtask

    // Let every expected word drain and the pipeline settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers, plus the unused index, while the block is idle.
    task automatic set_config(input logic pairs, input logic strands, input logic totals);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_PAIR_STATS;
        cfg_wdata <= pairs;
        @(posedge aclk);
        pairs_cfg = pairs;
        cfg_index <= CFG_BOTH_STRAND;
        cfg_wdata <= strands;
        @(posedge aclk);
        strands_cfg = strands;
        cfg_index <= CFG_TOTALS_ONLY;
        cfg_wdata <= totals;
        @(posedge aclk);
        totals_cfg = totals;
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= 1'($urandom_range(0, 1));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly sequence letters of both cases, sometimes an arbitrary byte.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 13))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            4: return "a";
            5: return "c";
            6: return "g";
            7: return "t";
            8: return "U";
            9: return "u";
            10: return "N";
            11: return "C";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Default registers: every character class, then both report kinds.
    task automatic test_char_classes();
        send_word(word_of(FUNC_BASE, "A"));
        send_word(word_of(FUNC_BASE, "c"));
        send_word(word_of(FUNC_BASE, "G"));
        send_word(word_of(FUNC_BASE, "t"));
        send_word(word_of(FUNC_BASE, "U"));
        send_word(word_of(FUNC_BASE, "u"));
        send_word(word_of(FUNC_BASE, 8'h00));
        send_word(word_of(FUNC_BASE, 8'hFF));
        send_word(word_of(FUNC_BASE, "N"));
        send_word(word_of(FUNC_END_SEQ, 8'h00));
        send_word(word_of(FUNC_END_RUN, 8'hFF));
    endtask

    // Pair statistics on both strands, CpG steps and an empty sequence.
    task automatic test_strand_pairs();
        set_config(1'b1, 1'b1, 1'b0);
        send_word(word_of(FUNC_BASE, "C"));
        send_word(word_of(FUNC_BASE, "G"));
        send_word(word_of(FUNC_BASE, "c"));
        send_word(word_of(FUNC_BASE, "g"));
        send_word(word_of(FUNC_BASE, "A"));
        send_word(word_of(FUNC_BASE, "T"));
        send_word(word_of(FUNC_END_SEQ, 8'h55));
        send_word(word_of(FUNC_END_SEQ, 8'hAA));
        send_word(word_of(FUNC_END_RUN, 8'h00));
    endtask

    // Suppressed sequence reports, the unused code and a run end mid-sequence.
    task automatic test_totals_only();
        set_config(1'b1, 1'b0, 1'b1);
        send_word(word_of(FUNC_BASE, "C"));
        send_word(word_of(FUNC_BASE, "G"));
        send_word(word_of(FUNC_END_SEQ, 8'h00));
        send_word(word_of(FUNC_UNUSED, 8'hFF));
        send_word(word_of(FUNC_BASE, "A"));
        send_word(word_of(FUNC_END_RUN, 8'h00));
    endtask

    // Random sequences under every register setting, with some noise words.
    task automatic test_random_traffic();
        int counted;
        int seq_len;
        int per_setting;
        per_setting = RANDOM_WORDS / 8;
        for (int setting = 0; setting < 8; setting++) begin
            set_config(setting[0], setting[1], setting[2]);
            counted = 0;
            while (counted < per_setting) begin
                seq_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                for (int i = 0; i < seq_len; i++) begin
                    send_word(word_of(FUNC_BASE, pick_char()));
                    if ($urandom_range(0, 40) == 0) begin
                        send_word(word_of(FUNC_UNUSED, 8'($urandom_range(0, 255))));
                    end
                end
                // An occasional run end lands inside an open sequence.
                if ($urandom_range(0, 9) == 0) begin
                    send_word(word_of(FUNC_END_RUN, 8'($urandom_range(0, 255))));
                    counted++;
                end
                send_word(word_of(FUNC_END_SEQ, 8'($urandom_range(0, 255))));
                counted += seq_len + 1;
                if ($urandom_range(0, 3) == 0) begin
                    send_word(word_of(FUNC_END_RUN, 8'($urandom_range(0, 255))));
                    counted++;
                end
            end
            send_word(word_of(FUNC_END_RUN, 8'($urandom_range(0, 255))));
        end
        set_config(1'b0, 1'b0, 1'b0);
        send_word(word_of(FUNC_END_RUN, 8'h00));
    endtask

    initial begin
        clear_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_char_classes();
        test_strand_pairs();
        test_totals_only();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/nucc_pkg.sv
rtl/core/nucleotide_composition_counter.sv
rtl/core/nucc_checker.sv
tb/sv/tb.sv
